FILE: rtl/rtpad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpad_pkg: shared types and constants
// state encoding, angle table and gain constant for the polar conversion unit
// ----------------------------------------------------------------------------
package rtpad_pkg;

    localparam int FRAC_BITS = 8;
    localparam int TABLE_LEN = 24;
    localparam int GAIN_BITS = 32;
    localparam logic [GAIN_BITS-1:0] INV_GAIN = 32'd2608131496;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROT,
        ST_MUL,
        ST_FIN
    } t_state;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/rect_to_polar_angle_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rect_to_polar_angle_distance: distance and heading between two points
// vectoring cordic on the point difference, then serial gain correction
// ----------------------------------------------------------------------------
// usage:
//   drive i_ref_x, i_ref_y, i_pt_x, i_pt_y and raise start while busy is low;
//   the transfer happens at that clock edge and busy rises on the next cycle.
//   the block then forms the difference, runs ITERATIONS micro-rotations
//   (at most 24) one per cycle, and applies the inverse gain with a
//   bit-serial multiplier, one gain bit per cycle.
//   o_valid pulses for one cycle with o_distance and o_heading; the result
//   transfer happens on that edge and the receiver cannot stall it.
//   one item at a time: a new start is taken only when the block is idle
//   again, after the rotation loop and the serial multiplier are done.
//   start may be raised again in the cycle that o_valid is high.
//   coincident points give distance 0 and heading 0.
//   heading: 2^ANGLE_WIDTH is one full turn, counterclockwise from +x.
//   reset (synchronous, active low) returns the block to idle and drops any
//   item in flight.
// ----------------------------------------------------------------------------
module rect_to_polar_angle_distance #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16,
    parameter int ITERATIONS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_ref_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_ref_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_pt_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pt_y,
    output logic                               o_valid,
    output logic [COORD_WIDTH:0]               o_distance,
    output logic [ANGLE_WIDTH-1:0]             o_heading
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int XW = COORD_WIDTH + 11;
    localparam int NI = (ITERATIONS > rtpad_pkg::TABLE_LEN) ? rtpad_pkg::TABLE_LEN : ITERATIONS;
    localparam int IW = $clog2(NI);
    localparam int PW = XW - rtpad_pkg::FRAC_BITS;
    localparam logic [31:0] HALF  = 32'h80000000;
    localparam logic [31:0] RND   = 32'(64'd1 << (31 - ANGLE_WIDTH));
    localparam logic [PW-1:0] DMAX = PW'((64'd1 << DW) - 64'd1);

    rtpad_pkg::t_state r_state, n_state;

    logic signed [DW-1:0] r_dx, n_dx;
    logic signed [DW-1:0] r_dy, n_dy;
    logic signed [XW-1:0] r_x, n_x;
    logic signed [XW-1:0] r_y, n_y;
    logic [31:0]          r_z, n_z;
    logic [IW-1:0]        r_it, n_it;
    logic                 r_mul_go, n_mul_go;
    logic                 r_valid, n_valid;
    logic [DW-1:0]        r_dist, n_dist;
    logic [ANGLE_WIDTH-1:0] r_head, n_head;

    logic [DW-1:0]        ax, ay;
    logic signed [XW-1:0] xs, ys;
    logic [31:0]          at, zq, zr;
    logic                 mul_done;
    logic [XW-1:0]        mul_prod;
    logic [PW-1:0]        pd;

    rtpad_gain_mul #(
        .XW(XW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_go),
        .i_operand ((r_x > 0) ? XW'(r_x) : '0),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    always_comb begin
        ax = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        ay = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
        xs = r_x >>> r_it;
        ys = r_y >>> r_it;
        at = rtpad_pkg::atan_turn(5'(r_it));
        if (r_dx[DW-1] && !r_dy[DW-1]) begin
            zq = HALF - r_z;
        end else if (r_dx[DW-1]) begin
            zq = HALF + r_z;
        end else if (r_dy[DW-1]) begin
            zq = 32'd0 - r_z;
        end else begin
            zq = r_z;
        end
        zr = zq + RND;
        pd = mul_prod[XW-1:rtpad_pkg::FRAC_BITS];

        n_state  = r_state;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_it     = r_it;
        n_mul_go = 1'b0;
        n_valid  = 1'b0;
        n_dist   = r_dist;
        n_head   = r_head;

        case (r_state)
            rtpad_pkg::ST_IDLE: begin
                if (start) begin
                    n_dx    = {i_pt_x[COORD_WIDTH-1], i_pt_x} - {i_ref_x[COORD_WIDTH-1], i_ref_x};
                    n_dy    = {i_pt_y[COORD_WIDTH-1], i_pt_y} - {i_ref_y[COORD_WIDTH-1], i_ref_y};
                    n_state = rtpad_pkg::ST_PREP;
                end
            end
            rtpad_pkg::ST_PREP: begin
                n_x     = signed'({2'b00, ax, {rtpad_pkg::FRAC_BITS{1'b0}}});
                n_y     = signed'({2'b00, ay, {rtpad_pkg::FRAC_BITS{1'b0}}});
                n_z     = '0;
                n_it    = '0;
                n_state = rtpad_pkg::ST_ROT;
            end
            rtpad_pkg::ST_ROT: begin
                if (!r_y[XW-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + at;
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - at;
                end
                n_it = r_it + 1'b1;
                if (r_it == IW'(NI - 1)) begin
                    n_mul_go = 1'b1;
                    n_state  = rtpad_pkg::ST_MUL;
                end
            end
            rtpad_pkg::ST_MUL: begin
                if (mul_done) begin
                    n_state = rtpad_pkg::ST_FIN;
                end
            end
            rtpad_pkg::ST_FIN: begin
                if (r_dx == '0 && r_dy == '0) begin
                    n_dist = '0;
                    n_head = '0;
                end else begin
                    n_dist = (pd > DMAX) ? DW'(DMAX) : DW'(pd);
                    n_head = zr[31 -: ANGLE_WIDTH];
                end
                n_valid = 1'b1;
                n_state = rtpad_pkg::ST_IDLE;
            end
            default: begin
                n_state = rtpad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rtpad_pkg::ST_IDLE;
            r_mul_go <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mul_go <= n_mul_go;
            r_valid  <= n_valid;
        end
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_it   <= n_it;
        r_dist <= n_dist;
        r_head <= n_head;
    end

    assign busy       = (r_state != rtpad_pkg::ST_IDLE);
    assign o_valid    = r_valid;
    assign o_distance = r_dist;
    assign o_heading  = r_head;

endmodule
`default_nettype wire

FILE: rtl/rtpad_gain_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpad_gain_mul: bit-serial gain multiplier
// multiplies the operand by the inverse cordic gain, one multiplier bit per
// cycle, and returns the product shifted down by the gain fraction bits
// ----------------------------------------------------------------------------
module rtpad_gain_mul #(
    parameter int XW = 35
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [XW-1:0] i_operand,
    output logic               o_done,
    output logic [XW-1:0]      o_product
);

    localparam int CW = $clog2(rtpad_pkg::GAIN_BITS);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [CW-1:0]                    r_cnt, n_cnt;
    logic [XW-1:0]                    r_acc, n_acc;
    logic [XW-1:0]                    r_mcand, n_mcand;
    logic [rtpad_pkg::GAIN_BITS-1:0]  r_g, n_g;
    logic [XW:0]                      sum;

    always_comb begin
        sum     = {1'b0, r_acc} + (r_g[0] ? {1'b0, r_mcand} : '0);
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_g     = r_g;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_acc   = '0;
            n_mcand = i_operand;
            n_g     = rtpad_pkg::INV_GAIN;
        end else if (r_busy) begin
            n_acc = sum[XW:1];
            n_g   = r_g >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(rtpad_pkg::GAIN_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_g     <= n_g;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
`default_nettype wire

FILE: tb/tb_rect_to_polar_angle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_to_polar_angle_distance: self-checking bench for the polar unit
// directed and random point pairs are sent through the command handshake;
// each accepted pair is converted to distance and heading by a bit-exact
// cordic predictor and checked against the strobed result in order
// ----------------------------------------------------------------------------
module tb_rect_to_polar_angle_distance;

    localparam int CW        = 24;
    localparam int AW        = 16;
    localparam int ROTATIONS = 16;
    localparam int LATENCY   = ROTATIONS + 37;
    localparam int WD_LIMIT  = 4000;
    localparam int N_RANDOM  = 1600;

    typedef struct {
        logic signed [CW-1:0] ref_x;
        logic signed [CW-1:0] ref_y;
        logic signed [CW-1:0] pt_x;
        logic signed [CW-1:0] pt_y;
    } t_points;

    typedef struct {
        logic [CW:0]   distance;
        logic [AW-1:0] heading;
    } t_polar;

    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CW-1:0] i_ref_x = '0;
    logic signed [CW-1:0] i_ref_y = '0;
    logic signed [CW-1:0] i_pt_x = '0;
    logic signed [CW-1:0] i_pt_y = '0;
    logic                 o_valid;
    logic [CW:0]          o_distance;
    logic [AW-1:0]        o_heading;

    t_points pending_points[$];
    t_polar  expected_polar[$];
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_errors = 0;
    int      idle_cycles = 0;
    int      idle_pct = 27;

    rect_to_polar_angle_distance #(
        .COORD_WIDTH(CW),
        .ANGLE_WIDTH(AW),
        .ITERATIONS(ROTATIONS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_ref_x(i_ref_x),
        .i_ref_y(i_ref_y),
        .i_pt_x(i_pt_x),
        .i_pt_y(i_pt_y),
        .o_valid(o_valid),
        .o_distance(o_distance),
        .o_heading(o_heading)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_polar to_polar(t_points p);
        t_polar      r;
        longint      dx, dy, x, y, xs, ys;
        logic [31:0] z;
        logic [63:0] ux, prod, mag;
        dx = longint'(p.pt_x) - longint'(p.ref_x);
        dy = longint'(p.pt_y) - longint'(p.ref_y);
        if (dx == 0 && dy == 0) begin
            r.distance = '0;
            r.heading = '0;
            return r;
        end
        x = (dx < 0 ? -dx : dx) * 256;
        y = (dy < 0 ? -dy : dy) * 256;
        z = '0;
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        if (dx < 0 && dy >= 0) z = 32'h80000000 - z;
        else if (dx < 0) z = 32'h80000000 + z;
        else if (dy < 0) z = 32'd0 - z;
        ux = x > 0 ? 64'(x) : 64'd0;
        prod = (ux >> 32) * 64'(rtpad_pkg::INV_GAIN)
             + (((ux & 64'hFFFFFFFF) * 64'(rtpad_pkg::INV_GAIN)) >> 32);
        mag = prod >> rtpad_pkg::FRAC_BITS;
        if (mag > 64'((1 << (CW + 1)) - 1)) mag = 64'((1 << (CW + 1)) - 1);
        z = z + (32'd1 << (31 - AW));
        r.distance = mag[CW:0];
        r.heading = z[31 -: AW];
        return r;
    endfunction

    task automatic add_pair(int rx, int ry, int px, int py);
        t_points p;
        p.ref_x = rx[CW-1:0];
        p.ref_y = ry[CW-1:0];
        p.pt_x = px[CW-1:0];
        p.pt_y = py[CW-1:0];
        pending_points.push_back(p);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 n_checked);
    endtask

    // driver: one nonblocking update per signal per edge
    always @(posedge i_clk) begin
        t_points p;
        logic    taken;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                p.ref_x = i_ref_x;
                p.ref_y = i_ref_y;
                p.pt_x = i_pt_x;
                p.pt_y = i_pt_y;
                expected_polar.push_back(to_polar(p));
                n_sent++;
                if (n_sent == 600) idle_pct = 74;
                if (n_sent == 1200) idle_pct = 0;
            end
            if (!start || taken) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    p = pending_points.pop_front();
                    start <= 1'b1;
                    i_ref_x <= p.ref_x;
                    i_ref_y <= p.ref_y;
                    i_pt_x <= p.pt_x;
                    i_pt_y <= p.pt_y;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: result transfer on every strobe
    always @(posedge i_clk) begin
        t_polar e;
        if (i_rst_n && o_valid) begin
            if (expected_polar.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                e = expected_polar.pop_front();
                if (o_distance !== e.distance)
                    report_mismatch("distance", int'(o_distance), int'(e.distance));
                if (o_heading !== e.heading)
                    report_mismatch("heading", int'(o_heading), int'(e.heading));
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired after %0d results", n_checked);
            $display("tb_rect_to_polar_angle_distance NOT OK");
            $finish;
        end
    end

    initial begin
        int mx, mn, rx, ry, d;
        mx = (1 << (CW - 1)) - 1;
        mn = -(1 << (CW - 1));
        // coincident points, axes, quadrants and extreme spans
        add_pair(0, 0, 0, 0);
        add_pair(mn, mx, mn, mx);
        add_pair(0, 0, 100, 0);
        add_pair(0, 0, -100, 0);
        add_pair(0, 0, 0, 100);
        add_pair(0, 0, 0, -100);
        add_pair(0, 0, 1, 1);
        add_pair(0, 0, -1, 1);
        add_pair(0, 0, -1, -1);
        add_pair(0, 0, 1, -1);
        add_pair(mn, mn, mx, mx);
        add_pair(mx, mx, mn, mn);
        add_pair(mn, mx, mx, mn);
        add_pair(mx, mn, mn, mx);
        add_pair(mn, 0, mx, 0);
        add_pair(0, mx, 0, mn);
        add_pair(5, 7, 5, 8);
        add_pair(-3, 9, -4, 9);
        add_pair(1000, -2000, 1000 + 3, -2000 - 70000);
        add_pair(mx, mx, mx, mx);
        for (int i = 0; i < N_RANDOM; i++) begin
            rx = $urandom;
            ry = $urandom;
            case ($urandom_range(3))
                0: add_pair(rx, ry, $urandom, $urandom);
                1: begin
                    d = $urandom_range(8);
                    add_pair(rx, ry, rx + $urandom_range(2 * d) - d,
                             ry + $urandom_range(2 * d) - d);
                end
                2: add_pair(rx, ry, rx + int'($urandom_range(2000)) - 1000,
                            ry + int'($urandom_range(2000)) - 1000);
                default: begin
                    d = $urandom_range(1);
                    add_pair(rx, ry, d ? rx : $urandom, d ? $urandom : ry);
                end
            endcase
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_points.size() == 0 && !start && expected_polar.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d point pairs, checked %0d results", n_sent, n_checked);
        $display("covered coincident points, axes, all quadrants and full-range spans");
        if (n_errors == 0 && expected_polar.size() == 0)
            $display("tb_rect_to_polar_angle_distance OK");
        else
            $display("tb_rect_to_polar_angle_distance NOT OK");
        $finish;
    end

endmodule
